// ===== hdl/x86_subset_execute_unit_macros.svh =====
// Assertion macros shared by the execute unit RTL files.
// Depends on nothing; included by modules that carry assertions.
`ifndef X86_SUBSET_EXECUTE_UNIT_MACROS_SVH
`define X86_SUBSET_EXECUTE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked on every rising clock edge outside reset.
`define XEU_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication with the consequent checked in the next cycle.
`define XEU_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define XEU_ASSERT_IMP(label, clk_s, rst_s, ante, cons)
`define XEU_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

// ===== hdl/xeu_pkg.sv =====
// Package for the execute unit: operation and operand codes, decoded record.
// Depends on nothing.
package xeu_pkg;

  localparam int unsigned MemWordsDefault = 512;
  localparam int unsigned InstSizeDefault = 64;
  localparam logic [3:0] RegSp = 4'd4;
  localparam logic [3:0] RegBp = 4'd5;

  typedef enum logic [3:0] {
    CMD_MOV = 4'd0, CMD_PUSH = 4'd1, CMD_POP = 4'd2, CMD_LEAVE = 4'd3,
    CMD_CALL = 4'd4, CMD_RET = 4'd5, CMD_ADD = 4'd6, CMD_SUB = 4'd7,
    CMD_CMP = 4'd8, CMD_JNE = 4'd9, CMD_JMP = 4'd10
  } cmd_t;

  localparam logic [3:0] KindEmpty = 4'd0;
  localparam logic [3:0] KindImm = 4'd1;
  localparam logic [3:0] KindReg = 4'd2;
  localparam logic [3:0] KindMemFirst = 4'd3;
  localparam logic [3:0] KindMemLast = 4'd11;

  localparam logic [0:0] CfgEntry = 1'b0;
  localparam logic [0:0] CfgStack = 1'b1;

  // Classified operation carried out by the back end.
  typedef enum logic [3:0] {
    OP_ERR, OP_MOV_RR, OP_MOV_RM, OP_MOV_MR, OP_MOV_IR, OP_PUSH, OP_POP,
    OP_LEAVE, OP_CALL, OP_RET, OP_ADD, OP_SUB, OP_CMP, OP_JNE, OP_JMP
  } op_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] imm;
    logic [3:0]  base;
    logic [3:0]  index;
    logic [1:0]  shift;
  } operand_t;

  typedef struct packed {
    op_t      op;
    operand_t src;
    operand_t dst;
  } decoded_t;

  function automatic logic is_mem(input logic [3:0] k);
    is_mem = (k >= KindMemFirst) && (k <= KindMemLast);
  endfunction

endpackage

// ===== hdl/xeu_if.sv =====
// Valid/ready channel interfaces for instructions, results and configuration.
// Depends on nothing.
interface xeu_inst_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic [3:0]  src_kind;
  logic [63:0] src_imm;
  logic [3:0]  src_base;
  logic [3:0]  src_index;
  logic [1:0]  src_scale_shift;
  logic [3:0]  dst_kind;
  logic [63:0] dst_imm;
  logic [3:0]  dst_base;
  logic [3:0]  dst_index;
  logic [1:0]  dst_scale_shift;
  modport source (output valid, command, src_kind, src_imm, src_base, src_index,
    src_scale_shift, dst_kind, dst_imm, dst_base, dst_index, dst_scale_shift,
    input ready);
  modport sink (input valid, command, src_kind, src_imm, src_base, src_index,
    src_scale_shift, dst_kind, dst_imm, dst_base, dst_index, dst_scale_shift,
    output ready);
endinterface

interface xeu_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] next_pc;
  logic        zero_flag;
  logic        sign_flag;
  logic        carry_flag;
  logic        overflow_flag;
  logic        status;
  modport source (output valid, next_pc, zero_flag, sign_flag, carry_flag,
    overflow_flag, status, input ready);
  modport sink (input valid, next_pc, zero_flag, sign_flag, carry_flag,
    overflow_flag, status, output ready);
endinterface

interface xeu_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/xeu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module xeu_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== hdl/xeu_front.sv =====
// Front end: accepts instructions, classifies them and queues the decoded record.
// Depends on xeu_pkg and the channel interfaces.
module xeu_front (
  input  logic            clk,
  input  logic            rst,
  xeu_inst_if.sink        inst,
  output xeu_pkg::decoded_t q_data,
  output logic            q_valid,
  input  logic            q_pop
);
  import xeu_pkg::*;

  localparam int unsigned Depth = 2;

  decoded_t   entries [Depth];
  logic [0:0] wr_ptr;
  logic [0:0] rd_ptr;
  logic [1:0] count;
  decoded_t   dec;
  logic       push;
  logic       s_ok;

  // Classify the operation from command and operand kinds.
  always_comb begin
    dec.src = '{inst.src_kind, inst.src_imm, inst.src_base, inst.src_index,
                inst.src_scale_shift};
    dec.dst = '{inst.dst_kind, inst.dst_imm, inst.dst_base, inst.dst_index,
                inst.dst_scale_shift};
    dec.op = OP_ERR;
    s_ok = (inst.src_kind <= KindMemLast) && (inst.dst_kind <= KindMemLast);
    if (s_ok) begin
      case (inst.command)
        CMD_MOV: begin
          if (inst.src_kind == KindReg && inst.dst_kind == KindReg) dec.op = OP_MOV_RR;
          else if (inst.src_kind == KindReg && is_mem(inst.dst_kind)) dec.op = OP_MOV_RM;
          else if (is_mem(inst.src_kind) && inst.dst_kind == KindReg) dec.op = OP_MOV_MR;
          else if (inst.src_kind == KindImm && inst.dst_kind == KindReg) dec.op = OP_MOV_IR;
        end
        CMD_PUSH: if (inst.src_kind == KindReg) dec.op = OP_PUSH;
        CMD_POP: if (inst.src_kind == KindReg) dec.op = OP_POP;
        CMD_LEAVE: dec.op = OP_LEAVE;
        CMD_CALL: dec.op = OP_CALL;
        CMD_RET: dec.op = OP_RET;
        CMD_ADD: if (inst.src_kind == KindReg && inst.dst_kind == KindReg) dec.op = OP_ADD;
        CMD_SUB: if (inst.src_kind == KindImm && inst.dst_kind == KindReg) dec.op = OP_SUB;
        CMD_CMP: if (inst.src_kind == KindImm && is_mem(inst.dst_kind)) dec.op = OP_CMP;
        CMD_JNE: dec.op = OP_JNE;
        CMD_JMP: dec.op = OP_JMP;
        default: dec.op = OP_ERR;
      endcase
    end
  end

  assign inst.ready = (count != 2'(Depth));
  assign push = inst.valid && inst.ready;
  assign q_valid = (count != 2'd0);
  assign q_data = entries[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= dec;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  `include "x86_subset_execute_unit_macros.svh"
  `XEU_ASSERT_IMP(a_no_pop_empty, clk, rst, q_pop, q_valid)
  `XEU_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= 2'(Depth))
  `XEU_ASSERT_NEXT(a_count_push_only, clk, rst, push && !q_pop, count == $past(count) + 2'd1)
endmodule

// ===== hdl/xeu_back.sv =====
// Back end: executes decoded instructions against registers, flags and memory.
// Depends on xeu_pkg, xeu_ram and the channel interfaces.
module xeu_back #(
  parameter int unsigned MemWords = xeu_pkg::MemWordsDefault,
  parameter int unsigned InstSize = xeu_pkg::InstSizeDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  xeu_pkg::decoded_t q_data,
  input  logic              q_valid,
  output logic              q_pop,
  xeu_cfg_if.sink           cfg,
  xeu_res_if.source         res
);
  import xeu_pkg::*;

  localparam int unsigned AW = $clog2(MemWords);

  typedef enum logic [0:0] {ST_EXEC, ST_MEM} st_t;

  st_t         state, state_next;
  logic [63:0] regs [16];
  logic [63:0] pc;
  logic [3:0]  flags;
  logic [63:0] sp_val, bp_val;
  logic [63:0] ea_s, ea_d, tgt, fall, rs_val, rd_val, sum;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [63:0] mem_wdata, mem_rdata;
  logic        out_valid;
  logic [63:0] out_pc;
  logic [3:0]  out_flags;
  logic        out_status;
  logic        fire;
  logic        needs_read;
  logic [63:0] pc_upd;
  logic [3:0]  flags_upd;
  logic        status_upd;
  logic        sp_we;
  logic [63:0] sp_data;
  logic        wb_we;
  logic [3:0]  wb_idx;
  logic [63:0] wb_data;

  // Effective address of one operand.
  function automatic logic [63:0] eff(input operand_t o, input logic [63:0] b,
                                      input logic [63:0] i);
    logic [63:0] si;
    si = i << o.shift;
    case (o.kind)
      4'd3: eff = o.imm;
      4'd4: eff = b;
      4'd5: eff = o.imm + b;
      4'd6: eff = b + i;
      4'd7: eff = o.imm + b + i;
      4'd8: eff = si;
      4'd9: eff = o.imm + si;
      4'd10: eff = b + si;
      4'd11: eff = o.imm + b + si;
      default: eff = '0;
    endcase
  endfunction

  function automatic logic [3:0] subf(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    subf = {(a[63] != b[63]) && (r[63] != a[63]), b > a, r[63], r == 64'd0};
  endfunction

  function automatic logic [AW-1:0] slot(input logic [63:0] a);
    slot = a[AW+2:3];
  endfunction

  assign sp_val = regs[RegSp];
  assign bp_val = regs[RegBp];
  assign rs_val = regs[q_data.src.base];
  assign rd_val = regs[q_data.dst.base];
  assign sum = rd_val + rs_val;
  assign ea_s = eff(q_data.src, regs[q_data.src.base], regs[q_data.src.index]);
  assign ea_d = eff(q_data.dst, regs[q_data.dst.base], regs[q_data.dst.index]);
  assign fall = pc + 64'(InstSize);
  assign tgt = (q_data.src.kind == KindImm) ? q_data.src.imm :
               (q_data.src.kind == KindReg) ? rs_val :
               is_mem(q_data.src.kind) ? ea_s : 64'd0;

  // Output register: loads a new result when empty or when the held one leaves.
  assign fire = !out_valid || res.ready;
  assign res.valid = out_valid;
  assign res.next_pc = out_pc;
  assign {res.overflow_flag, res.carry_flag, res.sign_flag, res.zero_flag} = out_flags;
  assign res.status = out_status;
  assign cfg.ready = 1'b1;

  always_comb begin
    case (q_data.op)
      OP_MOV_MR, OP_POP, OP_LEAVE, OP_RET, OP_CMP: needs_read = 1'b1;
      default: needs_read = 1'b0;
    endcase
  end

  // Sequencer: memory reads pass through ST_MEM for the registered RAM port.
  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    mem_re = 1'b0;
    mem_raddr = '0;
    case (state)
      ST_EXEC: begin
        if (q_valid && fire) begin
          if (needs_read) begin
            mem_re = 1'b1;
            mem_raddr = (q_data.op == OP_MOV_MR) ? slot(ea_s) :
                        (q_data.op == OP_CMP) ? slot(ea_d) :
                        (q_data.op == OP_LEAVE) ? slot(bp_val) : slot(sp_val);
            state_next = ST_MEM;
          end else begin
            q_pop = 1'b1;
          end
        end
      end
      ST_MEM: begin
        if (fire) begin
          q_pop = 1'b1;
          state_next = ST_EXEC;
        end
      end
      default: state_next = ST_EXEC;
    endcase
  end

  // Memory write for stores.
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = rs_val;
    if (state == ST_EXEC && q_valid && fire) begin
      case (q_data.op)
        OP_MOV_RM: begin mem_we = 1'b1; mem_waddr = slot(ea_d); end
        OP_PUSH: begin mem_we = 1'b1; mem_waddr = slot(sp_val - 64'd8); end
        OP_CALL: begin
          mem_we = 1'b1; mem_waddr = slot(sp_val - 64'd8); mem_wdata = fall;
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  xeu_ram #(.Width(64), .Depth(MemWords)) u_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_EXEC;
    else state <= state_next;
  end

  // Outcome of the instruction at the head of the queue. The destination
  // port wins over the stack port, so a pop into the stack pointer keeps
  // the loaded value.
  always_comb begin
    pc_upd = fall;
    flags_upd = 4'd0;
    status_upd = 1'b0;
    sp_we = 1'b0;
    sp_data = sp_val;
    wb_we = 1'b0;
    wb_idx = q_data.dst.base;
    wb_data = rs_val;
    case (q_data.op)
      OP_MOV_RR: wb_we = 1'b1;
      OP_MOV_IR: begin wb_we = 1'b1; wb_data = q_data.src.imm; end
      OP_MOV_MR: begin wb_we = 1'b1; wb_data = mem_rdata; end
      OP_MOV_RM: wb_we = 1'b0;
      OP_PUSH: begin sp_we = 1'b1; sp_data = sp_val - 64'd8; end
      OP_POP: begin
        sp_we = 1'b1; sp_data = sp_val + 64'd8;
        wb_we = 1'b1; wb_idx = q_data.src.base; wb_data = mem_rdata;
      end
      OP_LEAVE: begin
        sp_we = 1'b1; sp_data = bp_val + 64'd8;
        wb_we = 1'b1; wb_idx = RegBp; wb_data = mem_rdata;
      end
      OP_CALL: begin
        sp_we = 1'b1; sp_data = sp_val - 64'd8; pc_upd = tgt;
      end
      OP_RET: begin
        sp_we = 1'b1; sp_data = sp_val + 64'd8; pc_upd = mem_rdata;
      end
      OP_ADD: begin
        wb_we = 1'b1; wb_data = sum;
        flags_upd = {(rd_val[63] == rs_val[63]) && (sum[63] != rd_val[63]),
                     sum < rs_val, sum[63], sum == 64'd0};
      end
      OP_SUB: begin
        wb_we = 1'b1; wb_data = rd_val - q_data.src.imm;
        flags_upd = subf(rd_val, q_data.src.imm);
      end
      OP_CMP: flags_upd = subf(mem_rdata, q_data.src.imm);
      OP_JNE: begin
        if (!flags[0]) pc_upd = tgt;
      end
      OP_JMP: pc_upd = tgt;
      default: begin
        status_upd = 1'b1;
        pc_upd = pc;
        flags_upd = flags;
      end
    endcase
  end

  // Architectural state update and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 16; k++) regs[k] <= '0;
      pc <= '0;
      flags <= '0;
      out_valid <= 1'b0;
    end else begin
      for (int k = 0; k < 16; k++) begin
        if (q_pop && wb_we && wb_idx == 4'(k)) regs[k] <= wb_data;
        else if (q_pop && sp_we && RegSp == 4'(k)) regs[k] <= sp_data;
        else if (cfg.valid && cfg.index == CfgStack && RegSp == 4'(k)) regs[k] <= cfg.data;
      end
      if (q_pop) begin
        pc <= pc_upd;
        flags <= flags_upd;
      end else if (cfg.valid && cfg.index == CfgEntry) begin
        pc <= cfg.data;
      end
      if (q_pop) out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
    end
  end

  // Result payload, loaded with each transfer out of the queue.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_pc <= pc_upd;
      out_flags <= flags_upd;
      out_status <= status_upd;
    end
  end

  `include "x86_subset_execute_unit_macros.svh"
  `XEU_ASSERT_NEXT(a_pop_gives_result, clk, rst, q_pop, out_valid)
  `XEU_ASSERT_IMP(a_pop_only_when_free, clk, rst, q_pop, fire && q_valid)
  `XEU_ASSERT_NEXT(a_read_then_mem, clk, rst, mem_re, state == ST_MEM)
endmodule

// ===== hdl/x86_subset_execute_unit.sv =====
// Execute unit for a subset of x86-64: one decoded instruction in, one result
// out per transfer. Instructions with no memory read follow back to back every
// cycle while the result register is free to load; one that reads data memory
// (mov load, pop, leave, ret, cmp) also passes through a memory state for the
// registered read port of the data RAM. A two-entry queue parts decode from
// execution, and the result sits in an output register. Data memory has no
// reset; a read of a word never written returns undefined data.
module x86_subset_execute_unit #(
  parameter int unsigned MemWords = xeu_pkg::MemWordsDefault,
  parameter int unsigned InstSize = xeu_pkg::InstSizeDefault
) (
  input logic       clk,
  input logic       rst,
  xeu_inst_if.sink  inst,
  xeu_cfg_if.sink   cfg,
  xeu_res_if.source res
);
  import xeu_pkg::*;

  decoded_t q_data;
  logic     q_valid;
  logic     q_pop;

  // Decode and queue.
  xeu_front u_front (
    .clk(clk), .rst(rst), .inst(inst),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
  );

  // Execution.
  xeu_back #(.MemWords(MemWords), .InstSize(InstSize)) u_back (
    .clk(clk), .rst(rst), .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop),
    .cfg(cfg), .res(res)
  );
endmodule
